// File: rtl/core/flptw_pkg.sv
// ----------------------------------------------------------------------------
// flptw_pkg
// Shared types and constants for the four-level page table walker.
// ----------------------------------------------------------------------------
package flptw_pkg;

    // operation codes on the request channel
    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_ANSWER    = 1'b1;

    // result kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // walk levels: idle, then waiting for the entry of level one to four
    localparam int   LEVEL_W    = 3;
    localparam logic [LEVEL_W-1:0] LVL_IDLE = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_PML4 = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_PDPT = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_PD   = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_PT   = 3'd4;

    // entry bit positions
    localparam int PRESENT_POS = 0;
    localparam int LARGE_POS   = 7;

    // table base ignores its low four bits
    localparam logic [63:0] BASE_MASK = ~64'hf;

    // one input request
    typedef struct packed {
        logic        operation;
        logic [63:0] table_base;
        logic [47:0] virtual_address;
        logic [63:0] entry_word;
    } t_in_item;

    // one result
    typedef struct packed {
        logic        kind;
        logic [63:0] read_address;
        logic [63:0] physical_address;
        logic        fault;
    } t_out_item;

    // handshake between input stage and walk stage
    typedef struct packed {
        logic valid;
        logic advance;
    } t_stage_ctl;

endpackage

// File: rtl/core/flptw_in_stage.sv
// ----------------------------------------------------------------------------
// flptw_in_stage
// Input register: captures one request and holds it until the walk stage
// takes it.
// ----------------------------------------------------------------------------
module flptw_in_stage
    import flptw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_in_item   i_item,
    input  logic       i_advance,
    output logic       o_stage_valid,
    output t_in_item   o_stage_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     w_ready;
    logic     w_accept;

    // free when empty or when the held request moves on this cycle
    assign w_ready  = !r_valid || i_advance;
    assign w_accept = i_valid && w_ready;
    assign o_stall  = !w_ready;

    // valid flag next state
    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_stage_valid = r_valid;
    assign o_stage_item  = r_item;

endmodule

// File: rtl/core/flptw_walk_stage.sv
// ----------------------------------------------------------------------------
// flptw_walk_stage
// Walk state, single-pass entry decode and the result register.
// ----------------------------------------------------------------------------
module flptw_walk_stage
    import flptw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_stage_ctl i_ctl,
    input  t_in_item   i_item,
    output logic       o_can_advance,
    output logic       o_valid,
    input  logic       i_stall,
    output t_out_item  o_item
);

    logic [LEVEL_W-1:0] r_level;
    logic [LEVEL_W-1:0] n_level;
    logic [47:0]        r_held;
    logic [47:0]        n_held;
    logic               r_out_valid;
    logic               n_out_valid;
    t_out_item          r_out;
    t_out_item          w_res;
    logic               w_emit;

    logic [63:0] w_entry;
    logic [63:0] w_frame;
    logic [63:0] w_gib_frame;
    logic        w_present;
    logic        w_large;

    // stage moves when the result register is free or drained this cycle
    assign o_can_advance = !r_out_valid || !i_stall;

    // entry field extraction
    assign w_entry     = i_item.entry_word;
    assign w_frame     = {28'd0, w_entry[35:12], 12'd0};
    assign w_gib_frame = {12'd0, w_entry[51:30], 30'd0};
    assign w_present   = w_entry[PRESENT_POS];
    assign w_large     = w_entry[LARGE_POS];

    // one step of the walk
    always_comb begin
        n_level = r_level;
        n_held  = r_held;
        w_emit  = 1'b0;
        w_res   = '0;
        if (i_ctl.advance) begin
            if (i_item.operation == OP_TRANSLATE) begin
                n_held             = i_item.virtual_address;
                n_level            = LVL_PML4;
                w_emit             = 1'b1;
                w_res.kind         = KIND_READ;
                w_res.read_address = (i_item.table_base & BASE_MASK)
                                   + {52'd0, i_item.virtual_address[47:39], 3'd0};
            end else begin
                case (r_level)
                    LVL_PML4: begin
                        w_emit = 1'b1;
                        if (!w_present) begin
                            n_level    = LVL_IDLE;
                            w_res.kind = KIND_DONE;
                            w_res.fault = 1'b1;
                        end else begin
                            n_level            = LVL_PDPT;
                            w_res.kind         = KIND_READ;
                            w_res.read_address = w_frame + {52'd0, r_held[38:30], 3'd0};
                        end
                    end
                    LVL_PDPT: begin
                        w_emit = 1'b1;
                        if (!w_present) begin
                            n_level     = LVL_IDLE;
                            w_res.kind  = KIND_DONE;
                            w_res.fault = 1'b1;
                        end else if (w_large) begin
                            n_level                = LVL_IDLE;
                            w_res.kind             = KIND_DONE;
                            w_res.physical_address = w_gib_frame + {34'd0, r_held[29:0]};
                        end else begin
                            n_level            = LVL_PD;
                            w_res.kind         = KIND_READ;
                            w_res.read_address = w_frame + {52'd0, r_held[29:21], 3'd0};
                        end
                    end
                    LVL_PD: begin
                        w_emit = 1'b1;
                        if (!w_present) begin
                            n_level     = LVL_IDLE;
                            w_res.kind  = KIND_DONE;
                            w_res.fault = 1'b1;
                        end else if (w_large) begin
                            n_level                = LVL_IDLE;
                            w_res.kind             = KIND_DONE;
                            w_res.physical_address = w_frame + {43'd0, r_held[20:0]};
                        end else begin
                            n_level            = LVL_PT;
                            w_res.kind         = KIND_READ;
                            w_res.read_address = w_frame + {52'd0, r_held[20:12], 3'd0};
                        end
                    end
                    LVL_PT: begin
                        // last level: no present check, zero frame faults
                        w_emit     = 1'b1;
                        n_level    = LVL_IDLE;
                        w_res.kind = KIND_DONE;
                        if (w_frame == 64'd0) begin
                            w_res.fault = 1'b1;
                        end else begin
                            w_res.physical_address = w_frame + {52'd0, r_held[11:0]};
                        end
                    end
                    default: begin
                        // idle or unused level: answer dropped
                        n_level = LVL_IDLE;
                    end
                endcase
            end
        end
    end

    // result valid next state
    always_comb begin
        if (i_ctl.advance) begin
            n_out_valid = w_emit;
        end else begin
            n_out_valid = r_out_valid && i_stall;
        end
    end

    // control and walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= LVL_IDLE;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_level     <= n_level;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.valid && i_ctl.advance && w_emit) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

// File: rtl/core/four_level_page_table_walker.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Four-level walker for 48-bit virtual addresses.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_valid / o_stall / i_item): operation 0 starts a walk
//   with a table base and virtual address, operation 1 returns the entry for
//   the last read. A new translate request drops any walk in progress.
//   Result channel (o_valid / i_stall / o_item): kind 0 asks for an entry
//   read at read_address, kind 1 ends the walk with physical_address and
//   fault. Each request gives at most one result; an answer while idle
//   gives none.
//   A request passes the input register, then the result register, and the
//   walk decode lies between them. Throughput: one request per cycle
//   unless the result stalls; the decode is a single pass of masks, one
//   64-bit add and a few compares.
//   Reset (i_rst_n low, synchronous) empties both registers and returns the
//   walker to idle. While the receiver stalls, the result holds; one more
//   request is still taken into the input register, then o_stall rises.
// ----------------------------------------------------------------------------
module four_level_page_table_walker
    import flptw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic       w_stage_valid;
    t_in_item   w_stage_item;
    logic       w_can_advance;
    t_stage_ctl w_ctl;

    // held request moves into the walk stage when the result side allows
    assign w_ctl.valid   = w_stage_valid;
    assign w_ctl.advance = w_stage_valid && w_can_advance;

    flptw_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_item        (i_item),
        .i_advance     (w_ctl.advance),
        .o_stage_valid (w_stage_valid),
        .o_stage_item  (w_stage_item)
    );

    flptw_walk_stage u_walk_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_item        (w_stage_item),
        .o_can_advance (w_can_advance),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_item        (o_item)
    );

endmodule
